// ===== rtl/core/countdown_timer_controller_assert.svh =====
// Assertion macros shared by the countdown timer controller RTL.
`ifndef COUNTDOWN_TIMER_CONTROLLER_ASSERT_SVH
`define COUNTDOWN_TIMER_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("countdown timer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("countdown timer assertion failed");

`endif

// ===== rtl/core/ctc_pkg.sv =====
// Package of shared constants and command/status types for the countdown timer.
`default_nettype none
package ctc_pkg;

	// Display size and derived widths
	localparam int PIXEL_COUNT = 256;
	localparam int LIT_W       = $clog2(PIXEL_COUNT + 1);
	localparam int DURATION_W  = 23;
	localparam int NUM_W       = DURATION_W + LIT_W;
	localparam int DIV_CNT_W   = $clog2(LIT_W);
	localparam logic [LIT_W-1:0] PIX_LIT = LIT_W'(PIXEL_COUNT);
	localparam logic [NUM_W-1:0] PIX_NUM = NUM_W'(PIXEL_COUNT);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LIT_W - 1);

	// Field widths
	localparam int REQ_W    = 2;
	localparam int DELTA_W  = 5;
	localparam int MODE_W   = 2;
	localparam int MIN_W    = 7;
	localparam int HUE_W    = 8;
	localparam int PERIOD_W = 10;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TURN  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PRESS = 2'd2;

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_SET = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIN = 2'd2;

	// Configuration register indexes
	localparam logic CFG_FRAME = 1'b0;
	localparam logic CFG_BLINK = 1'b1;

	// Timer constants
	localparam logic [MIN_W-1:0]      MIN_MINUTES     = 7'd1;
	localparam logic [MIN_W-1:0]      MAX_MINUTES     = 7'd90;
	localparam logic [MIN_W-1:0]      DEFAULT_MINUTES = 7'd5;
	localparam logic [DURATION_W-1:0] MS_PER_MINUTE   = 23'd60000;
	localparam logic [DURATION_W-1:0] ELAPSED_MAX     = 23'h7FFFFF;
	localparam logic [HUE_W-1:0]      FINISH_HUE_STEP = 8'd8;
	localparam logic [PERIOD_W-1:0]   FRAME_RESET     = 10'd50;
	localparam logic [PERIOD_W-1:0]   BLINK_RESET     = 10'd300;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic div_step;
		logic div_last;
		logic out_load;
	} ctc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_need;
	} ctc_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/ctc_datapath.sv =====
// Datapath of the countdown timer: timer state, progress divider and result register.
`default_nettype none
`include "countdown_timer_controller_assert.svh"
module ctc_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ctc_pkg::ctc_cmd_t                cmd,
	output      ctc_pkg::ctc_status_t             status,
	input  wire logic [ctc_pkg::REQ_W-1:0]        req_type,
	input  wire logic signed [ctc_pkg::DELTA_W-1:0] delta,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_index,
	input  wire logic [ctc_pkg::PERIOD_W-1:0]     cfg_data,
	output      logic [ctc_pkg::MODE_W-1:0]       mode,
	output      logic [ctc_pkg::MIN_W-1:0]        minutes,
	output      logic [ctc_pkg::LIT_W-1:0]        lit_count,
	output      logic [ctc_pkg::HUE_W-1:0]        hue,
	output      logic                             blink_on,
	output      logic                             redraw,
	output      logic                             exit_request
);

	// Latched request
	logic [ctc_pkg::REQ_W-1:0]   req_q;
	logic [ctc_pkg::DELTA_W-1:0] delta_q;

	// Configuration
	logic [ctc_pkg::PERIOD_W-1:0] frame_period_q, blink_period_q;

	// Timer state
	logic [ctc_pkg::MODE_W-1:0]     mode_q, mode_d;
	logic [ctc_pkg::MIN_W-1:0]      minutes_q, minutes_d;
	logic [ctc_pkg::DURATION_W-1:0] duration_q, duration_d;
	logic [ctc_pkg::DURATION_W-1:0] elapsed_q, elapsed_d;
	logic [ctc_pkg::PERIOD_W-1:0]   frame_q, frame_d;
	logic [ctc_pkg::PERIOD_W-1:0]   blinkc_q, blinkc_d;
	logic                           blink_q, blink_d;
	logic [ctc_pkg::HUE_W-1:0]      hue_q, hue_d;
	logic [ctc_pkg::LIT_W-1:0]      lit_q, lit_d;
	logic                           redraw_q, redraw_d;
	logic                           exit_q, exit_d;

	// Divider state
	logic [ctc_pkg::NUM_W-1:0] rem_q, rem_d;
	logic [ctc_pkg::NUM_W-1:0] dsh_q, dsh_d;
	logic [ctc_pkg::LIT_W-1:0] quo_q, quo_d;

	// Helpers
	logic [ctc_pkg::PERIOD_W-1:0]   frame_inc, blinkc_inc;
	logic [ctc_pkg::DURATION_W-1:0] el_inc;
	logic [ctc_pkg::MIN_W:0]        msum;
	logic                           frame_fire, run_done, div_ge;

	assign frame_inc  = frame_q + 1'b1;
	assign blinkc_inc = blinkc_q + 1'b1;
	assign el_inc     = (elapsed_q < ctc_pkg::ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign msum       = {1'b0, minutes_q} + {{3{delta_q[ctc_pkg::DELTA_W-1]}}, delta_q};
	assign frame_fire = frame_inc >= frame_period_q;
	assign run_done   = el_inc >= duration_q;
	assign div_ge     = rem_q >= dsh_q;

	// Flag a progress refresh that needs the divider
	assign status.div_need = (req_q == ctc_pkg::REQ_TICK) && (mode_q == ctc_pkg::MODE_RUN)
		&& !run_done && frame_fire;

	// Next state of the timer and the divider
	always_comb begin
		mode_d     = mode_q;
		minutes_d  = minutes_q;
		duration_d = duration_q;
		elapsed_d  = elapsed_q;
		frame_d    = frame_q;
		blinkc_d   = blinkc_q;
		blink_d    = blink_q;
		hue_d      = hue_q;
		lit_d      = lit_q;
		redraw_d   = redraw_q;
		exit_d     = exit_q;
		rem_d      = rem_q;
		dsh_d      = dsh_q;
		quo_d      = quo_q;
		if (cmd.exec) begin
			redraw_d = 1'b0;
			exit_d   = 1'b0;
			unique case (req_q)
				ctc_pkg::REQ_TICK: begin
					case (mode_q)
						ctc_pkg::MODE_SET: begin
							frame_d = frame_fire ? '0 : frame_inc;
							redraw_d = frame_fire;
						end
						ctc_pkg::MODE_RUN: begin
							elapsed_d = el_inc;
							if (run_done) begin
								mode_d   = ctc_pkg::MODE_FIN;
								blinkc_d = '0;
								blink_d  = 1'b1;
								lit_d    = ctc_pkg::PIX_LIT;
								hue_d    = hue_q + ctc_pkg::FINISH_HUE_STEP;
								redraw_d = 1'b1;
							end else if (frame_fire) begin
								frame_d  = '0;
								rem_d    = ctc_pkg::NUM_W'(el_inc) * ctc_pkg::PIX_NUM;
								dsh_d    = ctc_pkg::NUM_W'(duration_q) << (ctc_pkg::LIT_W - 1);
								quo_d    = '0;
								hue_d    = hue_q + 1'b1;
								redraw_d = 1'b1;
							end else begin
								frame_d = frame_inc;
							end
						end
						default: begin
							if (blinkc_inc >= blink_period_q) begin
								blinkc_d = '0;
								blink_d  = !blink_q;
								if (!blink_q) begin
									hue_d = hue_q + ctc_pkg::FINISH_HUE_STEP;
								end
								redraw_d = 1'b1;
							end else begin
								blinkc_d = blinkc_inc;
							end
						end
					endcase
				end
				ctc_pkg::REQ_TURN: begin
					if (mode_q == ctc_pkg::MODE_SET) begin
						if (msum[ctc_pkg::MIN_W] || msum < {1'b0, ctc_pkg::MIN_MINUTES}) begin
							minutes_d = ctc_pkg::MIN_MINUTES;
						end else if (msum > {1'b0, ctc_pkg::MAX_MINUTES}) begin
							minutes_d = ctc_pkg::MAX_MINUTES;
						end else begin
							minutes_d = msum[ctc_pkg::MIN_W-1:0];
						end
						redraw_d = 1'b1;
					end
				end
				ctc_pkg::REQ_PRESS: begin
					redraw_d = 1'b1;
					if (mode_q == ctc_pkg::MODE_SET) begin
						mode_d     = ctc_pkg::MODE_RUN;
						duration_d = ctc_pkg::DURATION_W'(minutes_q) * ctc_pkg::MS_PER_MINUTE;
						elapsed_d  = '0;
						frame_d    = '0;
						lit_d      = '0;
					end else begin
						mode_d     = ctc_pkg::MODE_SET;
						minutes_d  = ctc_pkg::DEFAULT_MINUTES;
						duration_d = '0;
						elapsed_d  = '0;
						frame_d    = '0;
						blinkc_d   = '0;
						blink_d    = 1'b1;
						hue_d      = '0;
						lit_d      = '0;
						exit_d     = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		// One restoring division step, one quotient bit
		if (cmd.div_step) begin
			rem_d = div_ge ? rem_q - dsh_q : rem_q;
			dsh_d = dsh_q >> 1;
			quo_d = {quo_q[ctc_pkg::LIT_W-2:0], div_ge};
			if (cmd.div_last) begin
				lit_d = (quo_d > ctc_pkg::PIX_LIT) ? ctc_pkg::PIX_LIT : quo_d;
			end
		end
	end

	// Hold configuration and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q <= ctc_pkg::FRAME_RESET;
			blink_period_q <= ctc_pkg::BLINK_RESET;
			mode_q         <= ctc_pkg::MODE_SET;
			minutes_q      <= ctc_pkg::DEFAULT_MINUTES;
			duration_q     <= '0;
			elapsed_q      <= '0;
			frame_q        <= '0;
			blinkc_q       <= '0;
			blink_q        <= 1'b1;
			hue_q          <= '0;
			lit_q          <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					ctc_pkg::CFG_FRAME: frame_period_q <= cfg_data;
					ctc_pkg::CFG_BLINK: blink_period_q <= cfg_data;
					default: begin
					end
				endcase
			end
			mode_q     <= mode_d;
			minutes_q  <= minutes_d;
			duration_q <= duration_d;
			elapsed_q  <= elapsed_d;
			frame_q    <= frame_d;
			blinkc_q   <= blinkc_d;
			blink_q    <= blink_d;
			hue_q      <= hue_d;
			lit_q      <= lit_d;
		end
	end

	// Capture the request, divider words and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			delta_q <= delta;
		end
		redraw_q <= redraw_d;
		exit_q   <= exit_d;
		rem_q    <= rem_d;
		dsh_q    <= dsh_d;
		quo_q    <= quo_d;
		if (cmd.out_load) begin
			mode         <= mode_q;
			minutes      <= minutes_q;
			lit_count    <= lit_q;
			hue          <= hue_q;
			blink_on     <= blink_q;
			redraw       <= redraw_q;
			exit_request <= exit_q;
		end
	end

	`CTC_ASSERT_NOW(a_run_before_end, clk, arst_n, mode_q == ctc_pkg::MODE_RUN, elapsed_q < duration_q)
	`CTC_ASSERT_NOW(a_minutes_range, clk, arst_n, 1'b1, minutes_q >= ctc_pkg::MIN_MINUTES && minutes_q <= ctc_pkg::MAX_MINUTES)
	`CTC_ASSERT_NOW(a_lit_range, clk, arst_n, 1'b1, lit_q <= ctc_pkg::PIX_LIT)

endmodule
`default_nettype wire

// ===== rtl/core/ctc_ctrl.sv =====
// Controller state machine of the countdown timer: handshakes and step sequencing.
`default_nettype none
`include "countdown_timer_controller_assert.svh"
module ctc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output      logic                 item_stall,
	output      logic                 result_valid,
	input  wire logic                 result_stall,
	input  wire ctc_pkg::ctc_status_t status,
	output      ctc_pkg::ctc_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [ctc_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            out_free;

	assign item_stall = state_q != ST_IDLE;
	assign out_free   = !result_valid || !result_stall;

	// Decode commands from the current step
	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && item_valid;
		cmd.exec     = state_q == ST_EXEC;
		cmd.div_step = state_q == ST_DIV;
		cmd.div_last = (state_q == ST_DIV) && (cnt_q == ctc_pkg::DIV_LAST);
		cmd.out_load = (state_q == ST_DONE) && out_free;
	end

	// Advance the sequence and hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the receiver takes it
			if (cmd.out_load) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q   <= '0;
					state_q <= status.div_need ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ctc_pkg::DIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CTC_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, item_valid && !item_stall, item_stall)
	`CTC_ASSERT_NOW(a_div_count, clk, arst_n, state_q == ST_DIV, cnt_q <= ctc_pkg::DIV_LAST)
	`CTC_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.out_load, result_valid)

endmodule
`default_nettype wire

// ===== rtl/core/countdown_timer_controller.sv =====
// Top level of the countdown timer controller: controller plus datapath.
//
// Usage: requests arrive on the item channel (item_valid, item_stall) with
// req_type (tick, encoder turn, encoder press) and a signed encoder delta.
// Every accepted request yields exactly one result on the result channel
// (result_valid, result_stall): mode, minutes, lit_count, hue, blink_on,
// redraw and exit_request, taken at an edge with result_valid high and
// result_stall low.
// Sequence: an accepted request passes the exec step and then the done step,
// which loads the result and raises result_valid; a tick that refreshes the
// progress count while running goes through the restoring divider between
// them, one quotient bit per cycle. A new request is taken only while idle.
// A result waiting in the output register does not block the next request;
// that request is computed and held until the receiver stops stalling.
// Configuration: cfg_valid/cfg_ready writes frame_period_ms (index 0) or
// blink_period_ms (index 1); always ready, write only while idle.
// Reset (arst_n low) returns to setting mode at 5 minutes, periods 50/300.
`default_nettype none
module countdown_timer_controller (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output      logic                               item_stall,
	input  wire logic [ctc_pkg::REQ_W-1:0]          req_type,
	input  wire logic signed [ctc_pkg::DELTA_W-1:0] delta,
	output      logic                               result_valid,
	input  wire logic                               result_stall,
	output      logic [ctc_pkg::MODE_W-1:0]         mode,
	output      logic [ctc_pkg::MIN_W-1:0]          minutes,
	output      logic [ctc_pkg::LIT_W-1:0]          lit_count,
	output      logic [ctc_pkg::HUE_W-1:0]          hue,
	output      logic                               blink_on,
	output      logic                               redraw,
	output      logic                               exit_request,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic                               cfg_index,
	input  wire logic [ctc_pkg::PERIOD_W-1:0]       cfg_data
);

	ctc_pkg::ctc_cmd_t    cmd;
	ctc_pkg::ctc_status_t status;

	assign cfg_ready = 1'b1;

	ctc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	ctc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.delta        (delta),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.minutes      (minutes),
		.lit_count    (lit_count),
		.hue          (hue),
		.blink_on     (blink_on),
		.redraw       (redraw),
		.exit_request (exit_request)
	);

endmodule
`default_nettype wire
